FILE: rtl/core/ptu_pkg.sv
`default_nettype none
package ptu_pkg;

    localparam int NumVarsDef  = 256;
    localparam int FracBitsDef = 32;

    typedef enum logic [3:0] {
        t_IDLE,
        t_READ,
        t_GAIN,
        t_RELMUL,
        t_DIV_PC,
        t_MEANMUL,
        t_DIV_MEAN,
        t_SCOREMUL,
        t_WRITE,
        t_OUT
    } t_state;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] REG_ABS   = 2'd0;
    localparam logic [1:0] REG_REL   = 2'd1;
    localparam logic [1:0] REG_RELAX = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [7:0]  var_index;
        logic        direction;
        logic [63:0] parent_bound;
        logic [63:0] child_bound;
        logic [62:0] bisected_width;
        logic [63:0] relax_value;
        logic        relax_valid;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic [62:0] score;
        logic [62:0] left_mean;
        logic [62:0] right_mean;
        logic [31:0] left_total;
        logic [31:0] right_total;
    } t_out_item;

endpackage
`default_nettype wire

FILE: rtl/core/pseudocost_table_update_unit.sv
`default_nettype none
// Pseudocost table: one item at a time; busy stays high until the item is done. A
// record runs up to two 64-step bit-serial divides (pseudocost, running mean) and
// three multiplies sharing one 32x32 multiplier. The result is strobed on o_valid
// for one cycle as busy falls; the receiver cannot stall it and must take every
// result as it comes. The table is one 256-bit-wide synchronous RAM, read once
// per item and rewritten once per in-range record; valid bits give the all-zero
// reset, so no clearing pass is needed.
module pseudocost_table_update_unit #(
    parameter int NUM_VARS  = ptu_pkg::NumVarsDef,
    parameter int FRAC_BITS = ptu_pkg::FracBitsDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ptu_pkg::t_in_item  i_item,
    output logic                    o_valid,
    output ptu_pkg::t_out_item      o_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    localparam int IW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] EPS4 = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] EPS6 = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] M63  = 64'h7FFF_FFFF_FFFF_FFFF;

    ptu_pkg::t_state r_state, n_state;
    ptu_pkg::t_in_item r_in;
    logic [62:0] r_abs, r_rel;
    logic        r_relax;

    // table row: score, left mean, right mean, left count, right count
    logic [255:0] r_mem [NUM_VARS];
    logic [NUM_VARS-1:0] r_vld;
    logic [255:0] r_row;
    logic [63:0]  r_sc, r_lm, r_rm;
    logic [31:0]  r_lc, r_rc;
    logic [63:0]  r_gain, r_w, r_pc, r_n;
    logic         r_inr, r_pass;

    logic w_acc, w_wr;
    logic [7:0] w_idx8;
    logic [IW-1:0] w_idx;
    assign pready = 1'b1;
    assign w_acc = start && !busy;
    assign w_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs <= 63'd429;
            r_rel <= 63'd4294967;
            r_relax <= 1'b1;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                ptu_pkg::REG_ABS:   r_abs <= pwdata[62:0];
                ptu_pkg::REG_REL:   r_rel <= pwdata[62:0];
                ptu_pkg::REG_RELAX: r_relax <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[4:3])
            ptu_pkg::REG_ABS:   prdata = {1'b0, r_abs};
            ptu_pkg::REG_REL:   prdata = {1'b0, r_rel};
            ptu_pkg::REG_RELAX: prdata = {63'd0, r_relax};
            default:            prdata = '0;
        endcase
    end

    assign w_idx8 = r_in.var_index;
    assign w_idx = IW'(w_idx8);

    // shared multiplier and divider
    logic mul_start, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, div_hi, div_lo, div_d;
    logic [127:0] mul_p;
    logic [62:0] div_q;
    ptu_mul u_mul (.i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
                   .o_done(mul_done), .o_p(mul_p));
    ptu_div u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_hi(div_hi), .i_lo(div_lo),
                   .i_d(div_d), .o_done(div_done), .o_q(div_q));
    logic r_go;

    // combinational item math
    logic [63:0] w_frac, w_dist, w_eff, w_d, w_mag, w_ghi, w_glo;
    logic [63:0] w_gs;
    logic        w_cn, w_pn;
    logic [63:0] w_a, w_b;
    logic [127:0] w_gq;
    always_comb begin
        w_frac = r_in.relax_value & (ONE - 64'd1);
        if (r_in.direction) w_dist = w_frac;
        else w_dist = (w_frac == 64'd0) ? 64'd0 : ONE - w_frac;
        if ({1'b0, r_in.bisected_width} < ONE && r_relax && r_in.relax_valid)
            w_eff = (w_dist < EPS4) ? EPS4 : w_dist;
        else if ({1'b0, r_in.bisected_width} > ONE)
            w_eff = {1'b0, r_in.bisected_width};
        else
            w_eff = ONE;
        w_d = r_in.child_bound - r_in.parent_bound;
        w_cn = r_in.child_bound[63];
        w_pn = r_in.parent_bound[63];
        if (w_cn != w_pn && w_d[63] != w_cn)
            w_gs = w_cn ? 64'h8000_0000_0000_0000 : M63;
        else
            w_gs = w_d;
        w_mag = w_pn ? 64'(-r_in.parent_bound) : r_in.parent_bound;
        w_gq = {64'd0, r_gain} << FRAC_BITS;
        w_ghi = w_gq[127:64];
        w_glo = w_gq[63:0];
        w_a = (r_lm < EPS6) ? EPS6 : r_lm;
        w_b = (r_rm < EPS6) ? EPS6 : r_rm;
    end

    logic [127:0] w_ms;
    logic [127:0] w_sum;
    logic [63:0]  w_score;
    always_comb begin
        w_ms = mul_p >> FRAC_BITS;
        w_score = (w_ms[127:63] != '0) ? M63 : w_ms[63:0];
        w_sum = mul_p + {64'd0, r_pc};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptu_pkg::t_IDLE:     if (w_acc) n_state = ptu_pkg::t_READ;
            ptu_pkg::t_READ:     n_state = ptu_pkg::t_GAIN;
            ptu_pkg::t_GAIN:
                n_state = (!r_inr || r_in.operation == ptu_pkg::OP_QUERY) ?
                          ptu_pkg::t_OUT : ptu_pkg::t_RELMUL;
            ptu_pkg::t_RELMUL:   if (mul_done) n_state = ptu_pkg::t_DIV_PC;
            ptu_pkg::t_DIV_PC:
                if (div_done || (r_go && !r_pass)) n_state = ptu_pkg::t_MEANMUL;
            ptu_pkg::t_MEANMUL:  if (mul_done) n_state = ptu_pkg::t_DIV_MEAN;
            ptu_pkg::t_DIV_MEAN: if (div_done) n_state = ptu_pkg::t_SCOREMUL;
            ptu_pkg::t_SCOREMUL: if (mul_done) n_state = ptu_pkg::t_WRITE;
            ptu_pkg::t_WRITE:    n_state = ptu_pkg::t_OUT;
            ptu_pkg::t_OUT:      n_state = ptu_pkg::t_IDLE;
            default:             n_state = ptu_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_state != ptu_pkg::t_IDLE);
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a = {1'b0, r_rel};
        mul_b = w_mag;
        div_hi = w_ghi;
        div_lo = w_glo;
        div_d = r_w;
        unique case (r_state)
            ptu_pkg::t_GAIN: mul_start = r_inr && r_in.operation == ptu_pkg::OP_RECORD;
            ptu_pkg::t_DIV_PC: div_start = r_go && r_pass;
            ptu_pkg::t_MEANMUL: begin
                mul_a = r_n - 64'd1;
                mul_b = r_in.direction ? r_lm : r_rm;
                mul_start = r_go;
            end
            ptu_pkg::t_DIV_MEAN: begin
                div_hi = w_sum[127:64];
                div_lo = w_sum[63:0];
                div_d = r_n;
                div_start = r_go;
            end
            ptu_pkg::t_SCOREMUL: begin
                mul_a = w_a;
                mul_b = w_b;
                mul_start = r_go;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptu_pkg::t_IDLE;
            r_vld <= '0;
            o_valid <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ptu_pkg::t_OUT);
            r_go <= (n_state != r_state);
            if (r_state == ptu_pkg::t_WRITE) r_vld[w_idx] <= 1'b1;
        end
        if (w_acc) r_in <= i_item;
        if (r_state == ptu_pkg::t_READ) r_row <= r_mem[w_idx];
        if (r_state == ptu_pkg::t_WRITE) r_mem[w_idx] <= {r_sc, r_lm, r_rm, r_lc, r_rc};
        unique case (r_state)
            ptu_pkg::t_READ: begin
                r_inr <= ({24'd0, w_idx8} < 32'(NUM_VARS));
                r_gain <= w_gs;
                r_w <= w_eff;
            end
            ptu_pkg::t_GAIN: begin
                if (r_vld[w_idx]) begin
                    {r_sc, r_lm, r_rm, r_lc, r_rc} <= r_row;
                end else begin
                    {r_sc, r_lm, r_rm, r_lc, r_rc} <= '0;
                end
                r_pass <= !r_gain[63] && (r_gain >= {1'b0, r_abs});
            end
            ptu_pkg::t_RELMUL: if (mul_done) begin
                if (mul_p > {w_ghi, w_glo}) r_pass <= 1'b0;
                if (r_in.direction) r_n <= {32'd0, (r_lc == '1) ? r_lc : r_lc + 32'd1};
                else r_n <= {32'd0, (r_rc == '1) ? r_rc : r_rc + 32'd1};
                r_pc <= '0;
            end
            ptu_pkg::t_DIV_PC:
                if (div_done) r_pc <= ({1'b0, div_q} < EPS4) ? 64'd0 : {1'b0, div_q};
            ptu_pkg::t_DIV_MEAN: if (div_done) begin
                if (r_in.direction) begin
                    r_lm <= {1'b0, div_q};
                    r_lc <= r_n[31:0];
                end else begin
                    r_rm <= {1'b0, div_q};
                    r_rc <= r_n[31:0];
                end
            end
            ptu_pkg::t_SCOREMUL: if (mul_done) r_sc <= w_score;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ptu_pkg::t_OUT) begin
            o_item.entry_index <= w_idx8;
            o_item.score       <= r_inr ? r_sc[62:0] : '0;
            o_item.left_mean   <= r_inr ? r_lm[62:0] : '0;
            o_item.right_mean  <= r_inr ? r_rm[62:0] : '0;
            o_item.left_total  <= r_inr ? r_lc : '0;
            o_item.right_total <= r_inr ? r_rc : '0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/ptu_mul.sv
`default_nettype none
// 64x64 multiply, one 32x32 partial product per cycle
module ptu_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_p
);
    logic [2:0]   r_step, n_step;
    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc, n_acc;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_x = r_a[31:0];
        w_y = r_b[31:0];
        w_sh = '0;
        case (r_step)
            3'd1: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            3'd2: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            3'd3: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            3'd4: begin w_x = r_a[63:32]; w_y = r_b[63:32]; end
            default: begin w_x = r_a[31:0]; w_y = r_b[31:0]; end
        endcase
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        case (r_step)
            3'd1: w_sh = {64'd0, w_pp};
            3'd2, 3'd3: w_sh = {32'd0, w_pp, 32'd0};
            3'd4: w_sh = {w_pp, 64'd0};
            default: w_sh = '0;
        endcase
        n_acc = r_acc + w_sh;
        n_step = r_step;
        if (i_start) n_step = 3'd1;
        else if (r_step != 3'd0) n_step = (r_step == 3'd4) ? 3'd0 : r_step + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            r_step <= n_step;
            o_done <= (r_step == 3'd4);
        end
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_acc <= '0;
        end else if (r_step != 3'd0) begin
            r_acc <= n_acc;
        end
    end
    assign o_p = r_acc;
endmodule
`default_nettype wire

FILE: rtl/core/ptu_div.sv
`default_nettype none
// restoring 128/64 divide, one quotient bit per cycle, saturating at 2^63-1
module ptu_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_hi,
    input  wire logic [63:0]  i_lo,
    input  wire logic [63:0]  i_d,
    output logic              o_done,
    output logic [62:0]       o_q
);
    logic [6:0]  r_cnt;
    logic        r_run, r_sat;
    logic [63:0] r_r, r_lo, r_d, r_q;
    logic [64:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_r, r_lo[63]};
    assign w_ge = w_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= !((i_d == 64'd0) || (i_hi >= i_d));
                o_done <= (i_d == 64'd0) || (i_hi >= i_d);
            end else if (r_run && r_cnt == 7'd63) begin
                r_run <= 1'b0;
                o_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_r <= i_hi;
            r_lo <= i_lo;
            r_d <= i_d;
            r_q <= '0;
            r_cnt <= '0;
            r_sat <= (i_d == 64'd0) || (i_hi >= i_d);
        end else if (r_run) begin
            r_r <= w_ge ? 64'(w_sh - {1'b0, r_d}) : w_sh[63:0];
            r_lo <= {r_lo[62:0], 1'b0};
            r_q <= {r_q[62:0], w_ge};
            r_cnt <= r_cnt + 7'd1;
        end
    end
    assign o_q = (r_sat || r_q[63]) ? {63{1'b1}} : r_q[62:0];
endmodule
`default_nettype wire

FILE: rtl/core/ptu_checker.sv
`default_nettype none
module ptu_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic pready
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe too long");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");
endmodule

bind pseudocost_table_update_unit ptu_checker u_ptu_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .pready
);
`default_nettype wire
